// File: hdl/utd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utd_pkg;

  localparam int unsigned MAX_RES = 3;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int unsigned NRES_W  = $clog2(MAX_RES + 1);

  localparam logic [7:0] HI_BIT    = 8'h80;
  localparam logic [7:0] TOP2_MASK = 8'hc0;
  localparam logic [7:0] TOP3_MASK = 8'he0;
  localparam logic [7:0] TOP4_MASK = 8'hf0;
  localparam logic [7:0] LEAD2_PAT = 8'hc0;
  localparam logic [7:0] LEAD3_PAT = 8'he0;
  localparam logic [7:0] CONT_PAT  = 8'h80;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_LEAD = 2'd1,
    HELD_BOTH = 2'd2,
    HELD_XTRA = 2'd3
  } held_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        raw;
    logic        last;
    logic        eot;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]  units;
    logic [NRES_W-1:0]   count;
  } batch_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & TOP2_MASK) == CONT_PAT;
  endfunction

  function automatic logic is_lead2(input logic [7:0] b);
    return (b & TOP3_MASK) == LEAD2_PAT;
  endfunction

  function automatic logic is_lead3(input logic [7:0] b);
    return (b & TOP4_MASK) == LEAD3_PAT;
  endfunction

  function automatic logic is_ascii(input logic [7:0] b);
    return (b & HI_BIT) == 8'h00;
  endfunction

endpackage

`default_nettype wire

// File: hdl/utd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module utd_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_eos,
  output utd_pkg::batch_t      batch
);

  logic [7:0]      held_lead_r, held_lead_nxt;
  logic [7:0]      held_cont_r, held_cont_nxt;
  utd_pkg::held_t  held_cnt_r, held_cnt_nxt;

  logic                         do_fresh;
  logic [utd_pkg::NRES_W-1:0]   n;
  utd_pkg::batch_t              b_c;

  always_comb begin
    b_c           = '0;
    n             = '0;
    do_fresh      = 1'b0;
    held_lead_nxt = held_lead_r;
    held_cont_nxt = held_cont_r;
    held_cnt_nxt  = held_cnt_r;

    unique case (held_cnt_r)
      utd_pkg::HELD_NONE: begin
        do_fresh = 1'b1;
      end
      utd_pkg::HELD_LEAD: begin
        if (utd_pkg::is_cont(in_byte)) begin
          if (utd_pkg::is_lead2(held_lead_r)) begin
            b_c.units[n] = '{code_unit: {5'd0, held_lead_r[4:0], in_byte[5:0]},
                             raw: 1'b0, last: 1'b0, eot: 1'b0};
            n = n + 1'b1;
            held_lead_nxt = '0;
            held_cont_nxt = '0;
            held_cnt_nxt  = utd_pkg::HELD_NONE;
          end else begin
            held_cont_nxt = in_byte;
            held_cnt_nxt  = utd_pkg::HELD_BOTH;
          end
        end else begin
          b_c.units[n] = '{code_unit: {8'd0, held_lead_r}, raw: 1'b1,
                           last: 1'b0, eot: 1'b0};
          n = n + 1'b1;
          held_lead_nxt = '0;
          held_cont_nxt = '0;
          held_cnt_nxt  = utd_pkg::HELD_NONE;
          do_fresh      = 1'b1;
        end
      end
      utd_pkg::HELD_BOTH, utd_pkg::HELD_XTRA: begin
        if (utd_pkg::is_cont(in_byte)) begin
          b_c.units[n] = '{code_unit: {held_lead_r[3:0], held_cont_r[5:0], in_byte[5:0]},
                           raw: 1'b0, last: 1'b0, eot: 1'b0};
          n = n + 1'b1;
        end else begin
          b_c.units[n] = '{code_unit: {8'd0, held_lead_r}, raw: 1'b1,
                           last: 1'b0, eot: 1'b0};
          n = n + 1'b1;
          b_c.units[n] = '{code_unit: {8'd0, held_cont_r}, raw: 1'b1,
                           last: 1'b0, eot: 1'b0};
          n = n + 1'b1;
          do_fresh = 1'b1;
        end
        held_lead_nxt = '0;
        held_cont_nxt = '0;
        held_cnt_nxt  = utd_pkg::HELD_NONE;
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    if (do_fresh) begin
      if (utd_pkg::is_ascii(in_byte)) begin
        b_c.units[n] = '{code_unit: {8'd0, in_byte}, raw: 1'b0, last: 1'b0, eot: 1'b0};
        n = n + 1'b1;
      end else if (utd_pkg::is_lead2(in_byte) || utd_pkg::is_lead3(in_byte)) begin
        held_lead_nxt = in_byte;
        held_cont_nxt = '0;
        held_cnt_nxt  = utd_pkg::HELD_LEAD;
      end else begin
        b_c.units[n] = '{code_unit: {8'd0, in_byte}, raw: 1'b1, last: 1'b0, eot: 1'b0};
        n = n + 1'b1;
      end
    end

    // end of string: flush whatever is still held
    if (in_eos) begin
      if (held_cnt_nxt != utd_pkg::HELD_NONE) begin
        b_c.units[n] = '{code_unit: {8'd0, held_lead_nxt}, raw: 1'b1,
                         last: 1'b0, eot: 1'b0};
        n = n + 1'b1;
      end
      if (held_cnt_nxt == utd_pkg::HELD_BOTH || held_cnt_nxt == utd_pkg::HELD_XTRA) begin
        b_c.units[n] = '{code_unit: {8'd0, held_cont_nxt}, raw: 1'b1,
                         last: 1'b0, eot: 1'b0};
        n = n + 1'b1;
      end
      held_lead_nxt = '0;
      held_cont_nxt = '0;
      held_cnt_nxt  = utd_pkg::HELD_NONE;
    end

    if (n != '0) begin
      b_c.units[n - 1'b1].last = 1'b1;
      b_c.units[n - 1'b1].eot  = in_eos;
    end
    b_c.count = n;
  end

  assign batch = b_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lead_r <= '0;
      held_cont_r <= '0;
      held_cnt_r  <= utd_pkg::HELD_NONE;
    end else if (accept) begin
      held_lead_r <= held_lead_nxt;
      held_cont_r <= held_cont_nxt;
      held_cnt_r  <= held_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/utd_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module utd_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire utd_pkg::batch_t batch,
  output logic                 space_ok,
  output logic                 head_valid,
  input  wire logic            pop_ready,
  output utd_pkg::res_t        head
);

  utd_pkg::res_t                mem [utd_pkg::Q_DEPTH];
  logic [utd_pkg::PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [utd_pkg::PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [utd_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                         pop;
  logic [utd_pkg::NRES_W-1:0]   push_n;

  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign pop        = head_valid && pop_ready;
  assign push_n     = push ? batch.count : '0;
  // room for a worst-case batch
  assign space_ok   = (count_r <= utd_pkg::CNT_W'(utd_pkg::Q_DEPTH - utd_pkg::MAX_RES));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + utd_pkg::PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + utd_pkg::PTR_W'(pop);
    count_nxt  = count_r + utd_pkg::CNT_W'(push_n) - utd_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < utd_pkg::MAX_RES; k++) begin
      if (push && (utd_pkg::NRES_W'(k) < batch.count)) begin
        mem[wr_ptr_r + utd_pkg::PTR_W'(k)] <= batch.units[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/utf8_to_ucs2_decoder.sv
// UTF-8 to UCS-2 decoder. One text byte is taken per beat on the in_ channel and
// decoded combinationally into zero to three 16-bit code units, which land in a
// four-entry result queue and leave one per beat on the out_ channel, in order.
// Bytes that give zero or one unit sustain one byte per cycle while out_ready
// stays high. A byte that gives two or three units (a broken sequence, or a
// flush at end of string) stalls input until the queue drains: in_ready
// is high only while the queue holds at most one unit, so the single output port
// of the queue sets the rate. Stray continuations, 4-byte leads and bytes that
// cannot start a sequence are passed through raw with out_raw_passthrough set.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_ucs2_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_end_of_string,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_code_unit,
  output logic             out_raw_passthrough,
  output logic             out_last_of_run,
  output logic             out_end_of_text
);

  logic             accept;
  utd_pkg::batch_t  batch;
  utd_pkg::res_t    head;

  assign accept = in_valid && in_ready;

  utd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_eos  (in_end_of_string),
    .batch   (batch)
  );

  utd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .batch      (batch),
    .space_ok   (in_ready),
    .head_valid (out_valid),
    .pop_ready  (out_ready),
    .head       (head)
  );

  assign out_code_unit       = head.code_unit;
  assign out_raw_passthrough = head.raw;
  assign out_last_of_run     = head.last;
  assign out_end_of_text     = head.eot;

endmodule

`default_nettype wire

// File: hdl/utd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module utd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_code_unit,
  input wire logic        out_raw_passthrough,
  input wire logic        out_last_of_run,
  input wire logic        out_end_of_text
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_code_unit) && $stable(out_last_of_run)
      && $stable(out_raw_passthrough) && $stable(out_end_of_text))
    else $error("out payload changed while stalled");

  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> out_last_of_run)
    else $error("end of text not on last unit of a run");

  a_raw_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_raw_passthrough |-> out_code_unit[15:8] == 8'd0)
    else $error("raw unit wider than a byte");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty queue");

endmodule

bind utf8_to_ucs2_decoder utd_checker u_utd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_code_unit       (out_code_unit),
  .out_raw_passthrough (out_raw_passthrough),
  .out_last_of_run     (out_last_of_run),
  .out_end_of_text     (out_end_of_text)
);

`default_nettype wire
